>>> sv/awu_pkg.sv
package awu_pkg;

    // Number of features; each phase's store holds one weight per feature.
    localparam int FEATURE_COUNT = 1024;
    localparam int PHASE_COUNT   = 2;
    localparam int ADDR_W        = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1;

    // Pipeline depths of the root and quotient units.
    localparam int ROOT_STEPS = 32;
    localparam int QUO_BITS   = 34;

    localparam int HALF_Q24 = 8388608;
    localparam logic [24:0] ONE_Q24 = 25'h100_0000;
    localparam logic signed [40:0] MOM_MAX = 41'sh07F_FFFF_FFFF;
    localparam logic signed [40:0] MOM_MIN = -MOM_MAX - 41'sd1;
    localparam logic [QUO_BITS-1:0] STEP_CLAMP = QUO_BITS'(64'h2_0000_0000);

    localparam logic [31:0] GRADIENT_SCALE_RST = 32'd0;
    localparam logic [23:0] FIRST_DECAY_RST    = 24'd15099494;
    localparam logic [23:0] SECOND_DECAY_RST   = 24'd16760439;
    localparam logic [15:0] STABILITY_TERM_RST = 16'd43;

    typedef enum logic [1:0] {
        CFG_GRADIENT_SCALE = 2'd0,
        CFG_FIRST_DECAY    = 2'd1,
        CFG_SECOND_DECAY   = 2'd2,
        CFG_STABILITY_TERM = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic [9:0]         feature_index;
        logic signed [31:0] midgame_gradient;
        logic signed [31:0] endgame_gradient;
    } t_in;

    typedef struct packed {
        logic [9:0]         result_index;
        logic signed [31:0] midgame_weight;
        logic signed [31:0] endgame_weight;
    } t_out;

    typedef struct packed {
        logic [31:0] gradient_scale;
        logic [23:0] first_decay;
        logic [23:0] second_decay;
        logic [15:0] stability_term;
    } t_cfg;

    // Control that travels with an item down a lane.
    typedef struct packed {
        logic       valid;
        logic       in_range;
        logic [9:0] idx;
    } t_tag;

    typedef struct packed {
        logic              active;
        logic [ADDR_W-1:0] addr;
    } t_clear;

endpackage

>>> sv/awu_lane.sv
module awu_lane (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  awu_pkg::t_tag      i_tag,
    input  logic signed [31:0] i_gradient,
    input  awu_pkg::t_cfg      i_cfg,
    input  awu_pkg::t_clear    i_clear,
    output awu_pkg::t_tag      o_tag,
    output logic signed [31:0] o_weight
);

    localparam int AW = awu_pkg::ADDR_W;
    localparam int RS = awu_pkg::ROOT_STEPS;
    localparam int QB = awu_pkg::QUO_BITS;

    // State stores for this phase.
    logic [31:0] r_w_mem [awu_pkg::FEATURE_COUNT];
    logic [39:0] r_m_mem [awu_pkg::FEATURE_COUNT];
    logic [63:0] r_v_mem [awu_pkg::FEATURE_COUNT];

    // Front end: moment update, stages one to five.
    awu_pkg::t_tag r_t1, r_t2, r_t3, r_t4, r_t5;
    logic signed [31:0] r_g1;
    logic signed [39:0] r_m1, r_m2, r_m4, r_m5;
    logic [63:0] r_v1;
    logic [30:0] r_gm2;
    logic        r_neg2;
    logic [55:0] r_pvl2, r_pvh2;
    logic signed [64:0] r_p1_3;
    logic signed [56:0] r_p2_3;
    logic [61:0] r_sq3;
    logic [63:0] r_w1_3, r_w1_4;
    logic [23:0] r_f1_3, r_f1_4;
    logic [56:0] r_ql4;
    logic [54:0] r_qh4;
    logic [63:0] r_vp5;
    logic [1:0]  r_c5;

    logic [31:0] mag1;
    logic [63:0] prod1;
    logic [55:0] pvl1, pvh1;
    logic [24:0] c1, c2;
    logic signed [31:0] grad2;
    logic signed [64:0] p1_2;
    logic signed [56:0] p2_2;
    logic [61:0] sq2;
    logic [63:0] w1_2;
    logic signed [64:0] acc3;
    logic signed [40:0] mq3;
    logic signed [39:0] m3;
    logic [56:0] ql3;
    logic [54:0] qh3;
    logic [63:0] w2_4, vpre4;
    logic [25:0] fsum4;
    logic [63:0] v5;
    logic        mv_we;
    logic [AW-1:0] mv_addr;

    assign c1 = awu_pkg::ONE_Q24 - {1'b0, i_cfg.first_decay};
    assign c2 = awu_pkg::ONE_Q24 - {1'b0, i_cfg.second_decay};

    always_comb begin
        mag1  = r_g1[31] ? (~r_g1 + 32'd1) : r_g1;
        prod1 = {32'b0, mag1} * {32'b0, i_cfg.gradient_scale};
        pvl1  = {24'b0, r_v1[31:0]} * {32'b0, i_cfg.second_decay};
        pvh1  = {24'b0, r_v1[63:32]} * {32'b0, i_cfg.second_decay};
    end

    always_comb begin
        // A negative gradient sum moves the weight down.
        grad2 = r_neg2 ? $signed({1'b0, r_gm2}) : -$signed({1'b0, r_gm2});
        p1_2  = $signed({41'b0, i_cfg.first_decay}) * 65'(r_m2);
        p2_2  = $signed({32'b0, c1}) * 57'(grad2);
        sq2   = {31'b0, r_gm2} * {31'b0, r_gm2};
        w1_2  = {r_pvh2, 8'b0} + 64'(r_pvl2[55:24]);
    end

    always_comb begin
        acc3 = r_p1_3 + $signed({r_p2_3, 8'b0}) + 65'(awu_pkg::HALF_Q24);
        mq3  = acc3[64:24];
        if (mq3 > awu_pkg::MOM_MAX) begin
            m3 = awu_pkg::MOM_MAX[39:0];
        end else if (mq3 < awu_pkg::MOM_MIN) begin
            m3 = awu_pkg::MOM_MIN[39:0];
        end else begin
            m3 = mq3[39:0];
        end
        ql3 = {25'b0, r_sq3[31:0]} * {32'b0, c2};
        qh3 = {25'b0, r_sq3[61:32]} * {30'b0, c2};
    end

    always_comb begin
        w2_4  = 64'({r_qh4, 8'b0}) + 64'(r_ql4[56:24]);
        fsum4 = 26'(r_f1_4) + 26'(r_ql4[23:0]) + 26'(awu_pkg::HALF_Q24);
        vpre4 = r_w1_4 + w2_4;
        v5    = r_vp5 + 64'(r_c5);
    end

    assign mv_we   = i_clear.active | (i_adv & r_t5.valid & r_t5.in_range);
    assign mv_addr = i_clear.active ? i_clear.addr : AW'(r_t5.idx);

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_g1 <= i_gradient;
            r_m1 <= $signed(r_m_mem[AW'(i_tag.idx)]);
            r_v1 <= r_v_mem[AW'(i_tag.idx)];
        end
        if (mv_we) begin
            r_m_mem[mv_addr] <= i_clear.active ? 40'd0 : r_m5;
            r_v_mem[mv_addr] <= i_clear.active ? 64'd0 : v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_gm2  <= prod1[62:32];
            r_neg2 <= r_g1[31];
            r_m2   <= r_m1;
            r_pvl2 <= pvl1;
            r_pvh2 <= pvh1;
            r_p1_3 <= p1_2;
            r_p2_3 <= p2_2;
            r_sq3  <= sq2;
            r_w1_3 <= w1_2;
            r_f1_3 <= r_pvl2[23:0];
            r_m4   <= m3;
            r_ql4  <= ql3;
            r_qh4  <= qh3;
            r_w1_4 <= r_w1_3;
            r_f1_4 <= r_f1_3;
            r_m5   <= r_m4;
            r_vp5  <= vpre4;
            r_c5   <= fsum4[25:24];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1 <= '0;
            r_t2 <= '0;
            r_t3 <= '0;
            r_t4 <= '0;
            r_t5 <= '0;
        end else if (i_adv) begin
            r_t1 <= i_tag;
            r_t2 <= r_t1;
            r_t3 <= r_t2;
            r_t4 <= r_t3;
            r_t5 <= r_t4;
        end
    end

    // Square root, two radicand bits per stage.
    awu_pkg::t_tag      r_rt_tag [RS];
    logic signed [39:0] r_rt_m   [RS];
    logic [34:0]        r_rt_rem [RS];
    logic [31:0]        r_rt_q   [RS];
    logic [63:0]        r_rt_x   [RS];

    for (genvar k = 0; k < RS; k++) begin : g_root
        awu_pkg::t_tag      in_tag;
        logic signed [39:0] in_m;
        logic [34:0]        in_rem, rem_sh, trial, rem_n;
        logic [31:0]        in_q, q_n;
        logic [63:0]        in_x;

        if (k == 0) begin : g_first
            assign in_tag = r_t5;
            assign in_m   = r_m5;
            assign in_rem = '0;
            assign in_q   = '0;
            assign in_x   = v5;
        end else begin : g_next
            assign in_tag = r_rt_tag[k-1];
            assign in_m   = r_rt_m[k-1];
            assign in_rem = r_rt_rem[k-1];
            assign in_q   = r_rt_q[k-1];
            assign in_x   = r_rt_x[k-1];
        end

        always_comb begin
            rem_sh = {in_rem[32:0], in_x[63:62]};
            trial  = {1'b0, in_q, 2'b01};
            if (rem_sh >= trial) begin
                rem_n = rem_sh - trial;
                q_n   = {in_q[30:0], 1'b1};
            end else begin
                rem_n = rem_sh;
                q_n   = {in_q[30:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_rt_tag[k] <= '0;
            end else if (i_adv) begin
                r_rt_tag[k] <= in_tag;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_rt_m[k]   <= in_m;
                r_rt_rem[k] <= rem_n;
                r_rt_q[k]   <= q_n;
                r_rt_x[k]   <= {in_x[61:0], 2'b00};
            end
        end
    end

    // Divisor setup and range check ahead of the quotient pipeline.
    awu_pkg::t_tag r_dp_tag;
    logic [63:0]   r_dp_num;
    logic [48:0]   r_dp_d;
    logic          r_dp_ovf, r_dp_zero, r_dp_neg;

    logic [48:0] d_p;
    logic [39:0] mm_p;
    logic [63:0] num_p;
    logic signed [39:0] m_p;

    always_comb begin
        m_p   = r_rt_m[RS-1];
        d_p   = 49'({r_rt_q[RS-1], 16'b0}) + 49'(i_cfg.stability_term);
        mm_p  = m_p[39] ? 40'(-m_p) : 40'(m_p);
        num_p = {mm_p, 24'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dp_tag <= '0;
        end else if (i_adv) begin
            r_dp_tag <= r_rt_tag[RS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_dp_num  <= num_p;
            r_dp_d    <= d_p;
            r_dp_ovf  <= {19'b0, num_p} >= {d_p, 34'b0};
            r_dp_zero <= (d_p == '0);
            r_dp_neg  <= m_p[39];
        end
    end

    // Restoring division, one quotient bit per stage, top bit first.
    awu_pkg::t_tag r_dv_tag  [QB];
    logic [63:0]   r_dv_rem  [QB];
    logic [48:0]   r_dv_d    [QB];
    logic [QB-1:0] r_dv_q    [QB];
    logic          r_dv_ovf  [QB];
    logic          r_dv_zero [QB];
    logic          r_dv_neg  [QB];

    for (genvar j = 0; j < QB; j++) begin : g_div
        localparam int BIT = QB - 1 - j;
        awu_pkg::t_tag in_tag;
        logic [63:0]   in_rem, rem_n;
        logic [48:0]   in_d;
        logic [QB-1:0] in_q, q_n;
        logic          in_ovf, in_zero, in_neg, ge;
        logic [82:0]   dsh;

        if (j == 0) begin : g_first
            assign in_tag  = r_dp_tag;
            assign in_rem  = r_dp_num;
            assign in_d    = r_dp_d;
            assign in_q    = '0;
            assign in_ovf  = r_dp_ovf;
            assign in_zero = r_dp_zero;
            assign in_neg  = r_dp_neg;
        end else begin : g_next
            assign in_tag  = r_dv_tag[j-1];
            assign in_rem  = r_dv_rem[j-1];
            assign in_d    = r_dv_d[j-1];
            assign in_q    = r_dv_q[j-1];
            assign in_ovf  = r_dv_ovf[j-1];
            assign in_zero = r_dv_zero[j-1];
            assign in_neg  = r_dv_neg[j-1];
        end

        always_comb begin
            dsh   = 83'(in_d) << BIT;
            ge    = {19'b0, in_rem} >= dsh;
            rem_n = ge ? (in_rem - dsh[63:0]) : in_rem;
            q_n   = ge ? (in_q | (QB'(1) << BIT)) : in_q;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_tag[j] <= '0;
            end else if (i_adv) begin
                r_dv_tag[j] <= in_tag;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_dv_rem[j]  <= rem_n;
                r_dv_d[j]    <= in_d;
                r_dv_q[j]    <= q_n;
                r_dv_ovf[j]  <= in_ovf;
                r_dv_zero[j] <= in_zero;
                r_dv_neg[j]  <= in_neg;
            end
        end
    end

    // Step, weight read, and weight write back.
    awu_pkg::t_tag      r_wt;
    logic signed [34:0] r_st;
    logic signed [31:0] r_wr;

    logic [QB-1:0]      qc;
    logic signed [34:0] step;
    logic signed [35:0] wn;
    logic signed [31:0] wsat;
    logic               w_we;
    logic [AW-1:0]      w_addr;

    always_comb begin
        if (r_dv_ovf[QB-1] || (r_dv_q[QB-1] > awu_pkg::STEP_CLAMP)) begin
            qc = awu_pkg::STEP_CLAMP;
        end else begin
            qc = r_dv_q[QB-1];
        end
        if (r_dv_zero[QB-1]) begin
            step = '0;
        end else if (r_dv_neg[QB-1]) begin
            step = -$signed(35'(qc));
        end else begin
            step = $signed(35'(qc));
        end
    end

    always_comb begin
        wn = 36'(r_wr) - 36'(r_st);
        if (wn[35:31] == 5'b00000 || wn[35:31] == 5'b11111) begin
            wsat = wn[31:0];
        end else if (wn[35]) begin
            wsat = 32'sh8000_0000;
        end else begin
            wsat = 32'sh7FFF_FFFF;
        end
    end

    assign w_we   = i_clear.active | (i_adv & r_wt.valid & r_wt.in_range);
    assign w_addr = i_clear.active ? i_clear.addr : AW'(r_wt.idx);

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_st <= step;
            r_wr <= $signed(r_w_mem[AW'(r_dv_tag[QB-1].idx)]);
        end
        if (w_we) begin
            r_w_mem[w_addr] <= i_clear.active ? 32'd0 : wsat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wt <= '0;
        end else if (i_adv) begin
            r_wt <= r_dv_tag[QB-1];
        end
    end

    assign o_tag    = r_wt;
    assign o_weight = r_wt.in_range ? wsat : 32'sd0;

endmodule

>>> sv/adam_weight_update_core.sv
// Channel   Direction  Signals                               Contents
// input     in         i_in_valid, o_in_ready, i_in_item     feature index, two gradient sums
// output    out        o_out_valid, i_out_ready, o_out_item  feature index, two new weights
// config    in         i_cfg_we, i_cfg_index, i_cfg_data     four registers, write only
//
// One item is taken per cycle unless held back as described below; its result passes the
// moment stages, the 32-stage square root and the 34-stage quotient pipeline in each lane.
// After reset the stores are zeroed entry by entry, during which no item is taken.
// A stalled output freezes the whole pipeline; an item whose index matches one of
// the five items still updating their moments waits until that update is written.

module adam_weight_update_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  awu_pkg::t_in   i_in_item,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output awu_pkg::t_out  o_out_item,
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_index,
    input  logic [31:0]    i_cfg_data
);

    localparam int AW = awu_pkg::ADDR_W;

    // Moment stores are read when an item is accepted and written five stages
    // later, so five tags are kept here to hold back an item on the same index.
    localparam int HAZ_DEPTH = 5;

    awu_pkg::t_cfg   r_cfg;
    awu_pkg::t_clear r_clr;
    awu_pkg::t_tag   r_hz [HAZ_DEPTH];
    awu_pkg::t_out   r_out;
    logic            r_out_valid;

    logic            adv;
    logic            hazard;
    logic            accept;
    awu_pkg::t_tag   in_tag;
    awu_pkg::t_tag   tag_mid, tag_end;
    logic signed [31:0] w_mid, w_end;

    // The whole pipeline moves whenever the output register can take a result.
    assign adv = !r_out_valid | i_out_ready;

    always_comb begin
        hazard = 1'b0;
        for (int k = 0; k < HAZ_DEPTH; k++) begin
            if (r_hz[k].valid && r_hz[k].idx == i_in_item.feature_index) begin
                hazard = 1'b1;
            end
        end
    end

    assign o_in_ready = adv & !r_clr.active & !hazard;
    assign accept     = i_in_valid & o_in_ready;

    always_comb begin
        in_tag.valid    = accept;
        in_tag.in_range = ({22'b0, i_in_item.feature_index} <
                           32'(awu_pkg::FEATURE_COUNT));
        in_tag.idx      = i_in_item.feature_index;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < HAZ_DEPTH; k++) begin
                r_hz[k] <= '0;
            end
        end else if (adv) begin
            r_hz[0] <= in_tag;
            for (int k = 1; k < HAZ_DEPTH; k++) begin
                r_hz[k] <= r_hz[k-1];
            end
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gradient_scale <= awu_pkg::GRADIENT_SCALE_RST;
            r_cfg.first_decay    <= awu_pkg::FIRST_DECAY_RST;
            r_cfg.second_decay   <= awu_pkg::SECOND_DECAY_RST;
            r_cfg.stability_term <= awu_pkg::STABILITY_TERM_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                awu_pkg::CFG_GRADIENT_SCALE: r_cfg.gradient_scale <= i_cfg_data;
                awu_pkg::CFG_FIRST_DECAY:    r_cfg.first_decay    <= i_cfg_data[23:0];
                awu_pkg::CFG_SECOND_DECAY:   r_cfg.second_decay   <= i_cfg_data[23:0];
                awu_pkg::CFG_STABILITY_TERM: r_cfg.stability_term <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Clearing pass: one entry of every store per cycle after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr.active <= 1'b1;
            r_clr.addr   <= '0;
        end else if (r_clr.active) begin
            r_clr.addr <= r_clr.addr + AW'(1);
            if (r_clr.addr == AW'(awu_pkg::FEATURE_COUNT - 1)) begin
                r_clr.active <= 1'b0;
            end
        end
    end

    // One lane per phase; both see the same tags and the same stalls.
    awu_lane u_lane_mid (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (adv),
        .i_tag      (in_tag),
        .i_gradient (i_in_item.midgame_gradient),
        .i_cfg      (r_cfg),
        .i_clear    (r_clr),
        .o_tag      (tag_mid),
        .o_weight   (w_mid)
    );

    awu_lane u_lane_end (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (adv),
        .i_tag      (in_tag),
        .i_gradient (i_in_item.endgame_gradient),
        .i_cfg      (r_cfg),
        .i_clear    (r_clr),
        .o_tag      (tag_end),
        .o_weight   (w_end)
    );

    // Merge the two lanes into one result item. The lanes run in lockstep, so
    // an item is present in both or in neither.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= tag_mid.valid & tag_end.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out.result_index   <= tag_mid.idx;
            r_out.midgame_weight <= w_mid;
            r_out.endgame_weight <= w_end;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

>>> dv/adam_weight_update_core_tb.sv
`timescale 1ns / 100ps

module adam_weight_update_core_tb;

    localparam int  LATENCY     = 74;
    localparam int  CLEAR_TIME  = 1024;
    localparam int  CYCLE_LIMIT = 400000;
    localparam int  SLOTS       = awu_pkg::FEATURE_COUNT * awu_pkg::PHASE_COUNT;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_in_valid = 1'b0;
    logic          o_in_ready;
    awu_pkg::t_in  i_in_item = '0;
    logic          o_out_valid;
    logic          i_out_ready = 1'b0;
    awu_pkg::t_out o_out_item;
    logic          i_cfg_we = 1'b0;
    logic [1:0]    i_cfg_index = '0;
    logic [31:0]   i_cfg_data = '0;

    adam_weight_update_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Shadow copy of the block's registers and stores used by the predictor.
    logic [31:0]        sh_scale;
    logic [23:0]        sh_beta1;
    logic [23:0]        sh_beta2;
    logic [15:0]        sh_eps;
    logic signed [31:0] sh_weight   [SLOTS];
    logic signed [63:0] sh_momentum [SLOTS];
    logic [63:0]        sh_velocity [SLOTS];

    awu_pkg::t_in  pending_items[$];
    awu_pkg::t_out expected_weights[$];

    int  cycle_count = 0;
    int  error_count = 0;
    int  items_sent = 0;
    int  results_seen = 0;
    bit  quiet_mode = 1'b0;
    bit  stimulus_done = 1'b0;
    int  send_gap = 0;
    int  recv_gap = 0;

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // One Adam step on a single weight slot; returns the new saturated weight.
    function automatic logic signed [31:0] adam_step(int slot, logic signed [31:0] gsum);
        logic [63:0]         mag;
        logic [63:0]         gmag;
        logic signed [63:0]  grad;
        logic signed [127:0] acc;
        logic signed [127:0] mnew;
        logic [127:0]        vacc;
        logic [63:0]         vnew;
        logic [63:0]         den;
        logic [63:0]         mm;
        logic [127:0]        quo;
        logic signed [63:0]  stp;
        logic signed [63:0]  w;
        mag  = (gsum < 0) ? 64'(-64'(gsum)) : 64'(gsum);
        gmag = (mag * 64'(sh_scale)) >> 32;
        grad = (gsum < 0) ? $signed(gmag) : -$signed(gmag);
        acc  = 128'(sh_momentum[slot]) * $signed({1'b0, 64'(sh_beta1)})
             + $signed({1'b0, 64'(25'h100_0000 - sh_beta1)}) * 128'(grad * 256);
        mnew = (acc + 128'sd8388608) >>> 24;
        if (mnew > 128'sd549755813887) mnew = 128'sd549755813887;
        if (mnew < -128'sd549755813888) mnew = -128'sd549755813888;
        sh_momentum[slot] = 64'(mnew);
        // Velocity: whole and fractional parts are rounded together, as in the block.
        vacc = 128'(sh_velocity[slot]) * 128'(sh_beta2)
             + 128'(gmag * gmag) * 128'(25'h100_0000 - sh_beta2);
        vnew = 64'((vacc + 128'd8388608) >> 24);
        sh_velocity[slot] = vnew;
        den = (int_sqrt(vnew) << 16) + 64'(sh_eps);
        stp = 0;
        if (den != 0) begin
            mm  = (sh_momentum[slot] < 0) ? 64'(-sh_momentum[slot])
                                          : 64'(sh_momentum[slot]);
            quo = (128'(mm) << 24) / 128'(den);
            if (quo > 128'h2_0000_0000) quo = 128'h2_0000_0000;
            stp = (sh_momentum[slot] < 0) ? -64'(quo) : 64'(quo);
        end
        w = 64'(sh_weight[slot]) - stp;
        if (w > 64'sd2147483647) w = 64'sd2147483647;
        if (w < -64'sd2147483648) w = -64'sd2147483648;
        sh_weight[slot] = 32'(w);
        return 32'(w);
    endfunction

    function automatic awu_pkg::t_out predict_update(awu_pkg::t_in it);
        awu_pkg::t_out r;
        r = '0;
        r.result_index = it.feature_index;
        if (int'(it.feature_index) < awu_pkg::FEATURE_COUNT) begin
            r.midgame_weight = adam_step(int'(it.feature_index), it.midgame_gradient);
            r.endgame_weight = adam_step(int'(it.feature_index) + awu_pkg::FEATURE_COUNT,
                                         it.endgame_gradient);
        end
        return r;
    endfunction

    // Driver: the head of the queue is presented until the block takes it.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                expected_weights.push_back(predict_update(i_in_item));
                void'(pending_items.pop_front());
                items_sent <= items_sent + 1;
            end
            if (!(i_in_valid && !o_in_ready)) begin
                // A new item is chosen only when no item is waiting on the channel.
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    i_in_valid <= 1'b1;
                    i_in_item <= pending_items[0];
                    if (!quiet_mode && $urandom_range(0, 9) == 0)
                        send_gap <= $urandom_range(1, 9);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compares each accepted result with the oldest prediction.
    always @(posedge i_clk) begin
        awu_pkg::t_out exp_r;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                results_seen <= results_seen + 1;
                if (expected_weights.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, o_out_item);
                    error_count <= error_count + 1;
                end else begin
                    exp_r = expected_weights.pop_front();
                    if (exp_r !== o_out_item) begin
                        $display({"%0t: mismatch expected idx=%0d mg=%0d eg=%0d,",
                                  " actual idx=%0d mg=%0d eg=%0d"},
                                 $time, exp_r.result_index, exp_r.midgame_weight,
                                 exp_r.endgame_weight, o_out_item.result_index,
                                 o_out_item.midgame_weight, o_out_item.endgame_weight);
                        error_count <= error_count + 1;
                    end
                end
            end
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                if (!quiet_mode && $urandom_range(0, 9) == 0)
                    recv_gap <= $urandom_range(1, 9);
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout at cycle %0d", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic write_register(awu_pkg::t_cfg_index idx, logic [31:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            awu_pkg::CFG_GRADIENT_SCALE: sh_scale = value;
            awu_pkg::CFG_FIRST_DECAY:    sh_beta1 = value[23:0];
            awu_pkg::CFG_SECOND_DECAY:   sh_beta2 = value[23:0];
            awu_pkg::CFG_STABILITY_TERM: sh_eps   = value[15:0];
            default: ;
        endcase
    endtask

    task automatic add_item(int idx, logic [31:0] mg, logic [31:0] eg);
        awu_pkg::t_in it;
        it.feature_index = idx[9:0];
        it.midgame_gradient = mg;
        it.endgame_gradient = eg;
        pending_items.push_back(it);
    endtask

    // Waits until every item has gone through, then lets the pipeline drain.
    task automatic drain_block();
        while (pending_items.size() > 0 || i_in_valid || expected_weights.size() > 0)
            @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    function automatic logic [31:0] random_gradient();
        case ($urandom_range(0, 4))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 65535)) - 32768);
            2: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
            3: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return $urandom_range(0, 3) << 16;
        endcase
    endfunction

    // Random features are drawn mostly from a small set so slots are revisited
    // back to back and the moments build up over many steps.
    task automatic random_phase(int count);
        int idx;
        repeat (count) begin
            idx = $urandom_range(0, 3) == 0 ? $urandom_range(0, 1023) : $urandom_range(0, 15);
            add_item(idx, random_gradient(), random_gradient());
        end
    endtask

    initial begin
        sh_scale = awu_pkg::GRADIENT_SCALE_RST;
        sh_beta1 = awu_pkg::FIRST_DECAY_RST;
        sh_beta2 = awu_pkg::SECOND_DECAY_RST;
        sh_eps   = awu_pkg::STABILITY_TERM_RST;
        for (int k = 0; k < SLOTS; k++) begin
            sh_weight[k] = 0;
            sh_momentum[k] = 0;
            sh_velocity[k] = 0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // With the reset scale of zero, the gradient has no effect.
        add_item(0, 32'h7FFF_FFFF, 32'h8000_0000);
        drain_block();

        // Directed items at full scale and zero epsilon: field extremes, repeated
        // hits on one feature, and top index.
        write_register(awu_pkg::CFG_GRADIENT_SCALE, 32'hFFFF_FFFF);
        write_register(awu_pkg::CFG_STABILITY_TERM, 32'h0000_0000);
        add_item(1023, 32'h7FFF_FFFF, 32'h8000_0000);
        add_item(1023, 32'h8000_0000, 32'h7FFF_FFFF);
        add_item(5, 32'h0000_0000, 32'h0000_0000);
        add_item(5, 32'h0000_0001, 32'hFFFF_FFFF);
        add_item(5, 32'h0001_0000, 32'hFFFF_0000);
        add_item(5, 32'h0001_0000, 32'hFFFF_0000);
        add_item(512, 32'h5555_5555, 32'hAAAA_AAAA);
        add_item(512, 32'hAAAA_AAAA, 32'h5555_5555);
        // Zero denominator: velocity stays zero and epsilon is zero.
        add_item(700, 32'h0000_0000, 32'h0000_0000);
        drain_block();

        // Decay extremes: no memory at all, then nearly full memory.
        write_register(awu_pkg::CFG_FIRST_DECAY, 32'h0000_0000);
        write_register(awu_pkg::CFG_SECOND_DECAY, 32'h0000_0000);
        write_register(awu_pkg::CFG_STABILITY_TERM, 32'h0000_FFFF);
        add_item(9, 32'h0100_0000, 32'hFF00_0000);
        add_item(9, 32'h7FFF_FFFF, 32'h8000_0000);
        drain_block();
        write_register(awu_pkg::CFG_FIRST_DECAY, 32'h00FF_FFFF);
        write_register(awu_pkg::CFG_SECOND_DECAY, 32'h00FF_FFFF);
        add_item(9, 32'h0100_0000, 32'hFF00_0000);
        add_item(10, 32'h0000_0003, 32'hFFFF_FFFD);
        drain_block();

        // Random phases at several settings.
        write_register(awu_pkg::CFG_GRADIENT_SCALE, 32'h0010_0000);
        write_register(awu_pkg::CFG_FIRST_DECAY, 32'(awu_pkg::FIRST_DECAY_RST));
        write_register(awu_pkg::CFG_SECOND_DECAY, 32'(awu_pkg::SECOND_DECAY_RST));
        write_register(awu_pkg::CFG_STABILITY_TERM, 32'(awu_pkg::STABILITY_TERM_RST));
        random_phase(250);
        drain_block();

        write_register(awu_pkg::CFG_GRADIENT_SCALE, $urandom());
        write_register(awu_pkg::CFG_FIRST_DECAY, $urandom_range(0, 32'h00FF_FFFF));
        write_register(awu_pkg::CFG_SECOND_DECAY, $urandom_range(0, 32'h00FF_FFFF));
        write_register(awu_pkg::CFG_STABILITY_TERM, $urandom_range(0, 32'h0000_FFFF));
        random_phase(250);
        drain_block();

        write_register(awu_pkg::CFG_GRADIENT_SCALE, 32'hFFFF_FFFF);
        write_register(awu_pkg::CFG_STABILITY_TERM, 32'h0000_0001);
        random_phase(150);
        drain_block();

        // Final stretch with no idling on either side.
        quiet_mode = 1'b1;
        write_register(awu_pkg::CFG_GRADIENT_SCALE, 32'h0100_0000);
        random_phase(150);
        drain_block();

        $display("Sent %0d items and checked %0d results across several register settings,",
                 items_sent, results_seen);
        $display("covering decay and epsilon extremes, saturation and zero denominators.");
        if (error_count == 0 && expected_weights.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> adam_weight_update_core.f
sv/awu_pkg.sv
sv/awu_lane.sv
sv/adam_weight_update_core.sv
dv/adam_weight_update_core_tb.sv
